// ===== hdl/assert_macros.svh =====
// Assertion helpers, included by the top-level projection unit.
// All checks sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("check failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/cpp_pkg.sv =====
`default_nettype none
package cpp_pkg;

  // Number formats and screen geometry.
  localparam int FRAC_BITS     = 16;
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  // Camera-space coordinate width: 33-bit difference plus rotation growth.
  localparam int CW = 36;
  // Rotation term width: signed Q(FRAC_BITS) in the range -1.0 .. 1.0.
  localparam int TW = FRAC_BITS + 2;
  localparam int PW = CW + TW;
  localparam int FW = 16;             // focal scale width
  localparam int NW = CW + FW;        // |coord| * focal_scale
  localparam int QW = 33;             // quotient bits, magnitude cap is 2^QW
  localparam int RW = CW + 1;         // divider remainder width
  localparam int OW = CW + QW - 8;    // overflow compare width
  localparam int VW = 38;             // signed sum of magnitude and half screen
  localparam int AW = 16;             // angle width
  localparam int DW = 32;             // config data width
  localparam int IW = 3;              // config index width
  localparam int QDEPTH = 4;          // queue between front and back
  localparam int QAW = 2;

  localparam logic signed [CW-1:0] NEAR_LIMIT = CW'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [VW-1:0] HALF_X = VW'(longint'(SCREEN_WIDTH) << (FRAC_BITS - 1));
  localparam logic signed [VW-1:0] HALF_Y = VW'(longint'(SCREEN_HEIGHT) << (FRAC_BITS - 1));
  localparam logic signed [VW-1:0] SAT_MAX = VW'(longint'(2147483647));
  localparam logic signed [VW-1:0] SAT_MIN = VW'(-(longint'(1) << 31));
  localparam logic signed [31:0] CLIP_VALUE = 32'(-(longint'(1) << FRAC_BITS));
  localparam logic signed [TW-1:0] TERM_ONE = TW'(longint'(1) << FRAC_BITS);

  // Quarter-wave sine polynomial coefficients, Q30.
  localparam logic [31:0] POLY_C1 = 32'd1686629713;
  localparam logic [31:0] POLY_C3 = 32'd688904866;
  localparam logic [31:0] POLY_C5 = 32'd76016977;
  localparam logic [AW-1:0] QUARTER_TURN = 16'h4000;

  localparam logic signed [31:0] CAM_POS_Z_RESET = -32'sd327680;
  localparam logic [FW-1:0] FOCAL_RESET = 16'd640;

  typedef enum logic [IW-1:0] {
    REG_CAM_POS_X   = 3'd0,
    REG_CAM_POS_Y   = 3'd1,
    REG_CAM_POS_Z   = 3'd2,
    REG_CAM_ANGLE_X = 3'd3,
    REG_CAM_ANGLE_Y = 3'd4,
    REG_CAM_ANGLE_Z = 3'd5,
    REG_FOCAL_SCALE = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    TRIG_IDLE,
    TRIG_T2,
    TRIG_INNER,
    TRIG_MID,
    TRIG_SINE,
    TRIG_STORE
  } trig_state_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               clipped;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cam_pos_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [TW-1:0] cos_x;
    logic signed [TW-1:0] sin_x;
    logic signed [TW-1:0] cos_y;
    logic signed [TW-1:0] sin_y;
    logic signed [TW-1:0] cos_z;
    logic signed [TW-1:0] sin_z;
  } rot_terms_t;

  typedef struct packed {
    logic          we;
    axis_e         axis;
    logic [AW-1:0] value;
  } angle_wr_t;

endpackage
`default_nettype wire

// ===== hdl/cpp_trig.sv =====
`default_nettype none
module cpp_trig (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpp_pkg::angle_wr_t  angle_wr_i,
  output cpp_pkg::rot_terms_t terms_o,
  output logic                busy_o
);
  import cpp_pkg::*;

  localparam logic [32:0] ROUND_ADD = 33'(longint'(1) << (29 - FRAC_BITS));

  logic [AW-1:0] angle_q [3];
  logic [2:0]    pend_q, pend_d;
  trig_state_e   state_q, state_d;
  axis_e         axis_q, axis_d, sel_axis;
  logic          phase_q, phase_d;
  logic [AW-1:0] na_q, na_d, sel_na, ld_angle;
  logic [30:0]   t_q, t_d, t2_q, t2_d, ld_t;
  logic          neg_q, neg_d;
  logic [31:0]   acc_q, acc_d;
  rot_terms_t    terms_q, terms_d;
  logic [30:0]   mul_a;
  logic [31:0]   mul_b;
  logic [62:0]   prod;
  logic [31:0]   prod_s;
  logic [14:0]   ld_fold;
  logic [32:0]   rnd;
  logic [TW-1:0] term;

  // Shared multiplier; every product is taken back to Q30.
  assign prod   = 63'(mul_a) * 63'(mul_b);
  assign prod_s = prod[61:30];

  assign terms_o = terms_q;
  assign busy_o  = (state_q != TRIG_IDLE) || (|pend_q);

  // Latest angle of each axis.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q[0] <= '0;
      angle_q[1] <= '0;
      angle_q[2] <= '0;
    end else if (angle_wr_i.we) begin
      angle_q[angle_wr_i.axis] <= angle_wr_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_IDLE;
      pend_q  <= '0;
      terms_q <= '{cos_x: TERM_ONE, sin_x: '0, cos_y: TERM_ONE, sin_y: '0,
                   cos_z: TERM_ONE, sin_z: '0};
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      terms_q <= terms_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q  <= axis_d;
    phase_q <= phase_d;
    na_q    <= na_d;
    t_q     <= t_d;
    neg_q   <= neg_d;
    t2_q    <= t2_d;
    acc_q   <= acc_d;
  end

  // Sequencer: cosine then sine of the negated angle, one product per cycle.
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    axis_d  = axis_q;
    phase_d = phase_q;
    na_d    = na_q;
    t_d     = t_q;
    neg_d   = neg_q;
    t2_d    = t2_q;
    acc_d   = acc_q;
    terms_d = terms_q;
    mul_a   = '0;
    mul_b   = '0;
    rnd     = '0;
    term    = '0;

    priority if (pend_q[0]) begin
      sel_axis = AXIS_X;
    end else if (pend_q[1]) begin
      sel_axis = AXIS_Y;
    end else begin
      sel_axis = AXIS_Z;
    end
    sel_na = AW'(0) - angle_q[sel_axis];

    // Fold the angle into the first quadrant; the upper bit gives the sign.
    ld_angle = (state_q == TRIG_IDLE) ? (sel_na + QUARTER_TURN) : na_q;
    ld_fold  = ld_angle[14] ? (15'd16384 - {1'b0, ld_angle[13:0]})
                            : {1'b0, ld_angle[13:0]};
    ld_t     = {ld_fold, 16'b0};

    unique case (state_q)
      TRIG_IDLE: begin
        if (|pend_q) begin
          na_d             = sel_na;
          axis_d           = sel_axis;
          phase_d          = 1'b0;
          pend_d[sel_axis] = 1'b0;
          t_d              = ld_t;
          neg_d            = ld_angle[15];
          state_d          = TRIG_T2;
        end
      end
      TRIG_T2: begin
        mul_a   = t_q;
        mul_b   = {1'b0, t_q};
        t2_d    = prod_s[30:0];
        state_d = TRIG_INNER;
      end
      TRIG_INNER: begin
        mul_a   = t2_q;
        mul_b   = POLY_C5;
        acc_d   = POLY_C3 - prod_s;
        state_d = TRIG_MID;
      end
      TRIG_MID: begin
        mul_a   = t2_q;
        mul_b   = acc_q;
        acc_d   = POLY_C1 - prod_s;
        state_d = TRIG_SINE;
      end
      TRIG_SINE: begin
        mul_a   = t_q;
        mul_b   = acc_q;
        acc_d   = prod_s;
        state_d = TRIG_STORE;
      end
      TRIG_STORE: begin
        rnd  = ({1'b0, acc_q} + ROUND_ADD) >> (30 - FRAC_BITS);
        term = neg_q ? (TW'(0) - rnd[TW-1:0]) : rnd[TW-1:0];
        unique case (axis_q)
          AXIS_X: begin
            if (phase_q) terms_d.sin_x = term;
            else         terms_d.cos_x = term;
          end
          AXIS_Y: begin
            if (phase_q) terms_d.sin_y = term;
            else         terms_d.cos_y = term;
          end
          AXIS_Z: begin
            if (phase_q) terms_d.sin_z = term;
            else         terms_d.cos_z = term;
          end
          default: ;
        endcase
        if (!phase_q) begin
          phase_d = 1'b1;
          t_d     = ld_t;
          neg_d   = ld_angle[15];
          state_d = TRIG_T2;
        end else begin
          state_d = TRIG_IDLE;
        end
      end
      default: state_d = TRIG_IDLE;
    endcase

    // A new angle write always queues a recompute of its axis.
    if (angle_wr_i.we) begin
      pend_d[angle_wr_i.axis] = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cpp_front.sv =====
`default_nettype none
module cpp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cpp_pkg::in_item_t in_data_i,
  input  cpp_pkg::cam_pos_t cam_pos_i,
  input  logic              hold_i,
  output logic              full_o,
  input  logic              take_i,
  output logic              empty_o,
  output cpp_pkg::vec_t     head_o
);
  import cpp_pkg::*;

  vec_t             mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     cnt_q;
  logic             accept, take;
  vec_t             diff;

  assign full_o  = (cnt_q == (QAW + 1)'(QDEPTH)) || hold_i;
  assign empty_o = (cnt_q == '0);
  assign accept  = push_i && !full_o;
  assign take    = take_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Move the point into camera-relative coordinates.
  always_comb begin
    diff.x = CW'(in_data_i.point_x) - CW'(cam_pos_i.x);
    diff.y = CW'(in_data_i.point_y) - CW'(cam_pos_i.y);
    diff.z = CW'(in_data_i.point_z) - CW'(cam_pos_i.z);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_ptr_q] <= diff;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (take)   rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({accept, take})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cpp_rot.sv =====
`default_nettype none
module cpp_rot (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [cpp_pkg::CW-1:0]   u_i,
  input  logic signed [cpp_pkg::CW-1:0]   v_i,
  input  logic signed [cpp_pkg::CW-1:0]   w_i,
  input  logic signed [cpp_pkg::TW-1:0]   c_i,
  input  logic signed [cpp_pkg::TW-1:0]   s_i,
  output logic                            valid_o,
  output logic signed [cpp_pkg::CW-1:0]   u_o,
  output logic signed [cpp_pkg::CW-1:0]   v_o,
  output logic signed [cpp_pkg::CW-1:0]   w_o
);
  import cpp_pkg::*;

  logic                 valid1_q, valid2_q;
  logic signed [PW-1:0] uc_q, vs_q, us_q, vc_q;
  logic signed [CW-1:0] w1_q, w2_q, u2_q, v2_q;
  logic signed [PW:0]   a_sum, b_sum, a_sh, b_sh;

  // Rotated pair, floored back to Q(FRAC_BITS).
  always_comb begin
    a_sum = (PW + 1)'(uc_q) - (PW + 1)'(vs_q);
    b_sum = (PW + 1)'(us_q) + (PW + 1)'(vc_q);
    a_sh  = a_sum >>> FRAC_BITS;
    b_sh  = b_sum >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  // Products in the first stage, sums in the second.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uc_q <= u_i * c_i;
      vs_q <= v_i * s_i;
      us_q <= u_i * s_i;
      vc_q <= v_i * c_i;
      w1_q <= w_i;
      u2_q <= a_sh[CW-1:0];
      v2_q <= b_sh[CW-1:0];
      w2_q <= w1_q;
    end
  end

  assign valid_o = valid2_q;
  assign u_o     = u2_q;
  assign v_o     = v2_q;
  assign w_o     = w2_q;

endmodule
`default_nettype wire

// ===== hdl/cpp_back.sv =====
`default_nettype none
module cpp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  cpp_pkg::vec_t         head_i,
  output logic                  take_o,
  input  cpp_pkg::rot_terms_t   terms_i,
  input  logic [cpp_pkg::FW-1:0] focal_i,
  input  logic                  pop_i,
  output logic                  empty_o,
  output cpp_pkg::out_item_t    out_data_o
);
  import cpp_pkg::*;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] q;
  } div_lane_t;

  typedef struct packed {
    div_lane_t     lx;
    div_lane_t     ly;
    logic [CW-1:0] den;
    logic          neg_x;
    logic          neg_y;
    logic          ovf_x;
    logic          ovf_y;
    logic          clip;
  } div_t;

  // One restoring division step: one quotient bit.
  function automatic div_lane_t div_step(div_lane_t a, logic [CW-1:0] den);
    div_lane_t     r;
    logic [RW-1:0] r2;
    logic [RW:0]   diff;
    r2    = {a.rem[RW-2:0], a.low[QW-1]};
    diff  = {1'b0, r2} - {2'b0, den};
    r.low = {a.low[QW-2:0], 1'b0};
    if (!diff[RW]) begin
      r.rem = diff[RW-1:0];
      r.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      r.rem = r2;
      r.q   = {a.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Next divider stage: both lanes advance by one bit, the rest rides along.
  function automatic div_t div_next(div_t a);
    div_t r;
    r    = a;
    r.lx = div_step(a.lx, a.den);
    r.ly = div_step(a.ly, a.den);
    return r;
  endfunction

  function automatic logic signed [31:0] finish(logic [QW-1:0] q, logic ovf, logic neg,
                                                logic signed [VW-1:0] half);
    logic [QW:0]          mag;
    logic signed [VW-1:0] mag_s, v;
    mag   = ovf ? (QW + 1)'(longint'(1) << QW) : {1'b0, q};
    mag_s = VW'(mag);
    v     = (neg ? -mag_s : mag_s) + half;
    if (v > SAT_MAX)      v = SAT_MAX;
    else if (v < SAT_MIN) v = SAT_MIN;
    return v[31:0];
  endfunction

  logic                 en;
  logic                 r0_valid, r1_valid, r2_valid;
  logic signed [CW-1:0] r0_u, r0_v, r0_w, r1_u, r1_v, r1_w, r2_u, r2_v, r2_w;

  logic                 p_valid_q;
  logic                 p_clip_q, p_neg_x_q, p_neg_y_q;
  logic [CW-1:0]        p_mag_x_q, p_mag_y_q, p_den_q;
  logic                 m_valid_q;
  logic                 m_clip_q, m_neg_x_q, m_neg_y_q;
  logic [NW-1:0]        m_num_x_q, m_num_y_q;
  logic [CW-1:0]        m_den_q;

  logic [OW-1:0]        lim;
  logic [NW-1:0]        sh_x, sh_y, shl_x, shl_y;
  div_t                 d0;

  div_t                 st_q [QW+1];
  logic                 dv_q [QW+1];

  out_item_t            res;
  out_item_t            ofq [2];
  logic                 owp_q, orp_q;
  logic [1:0]           ocnt_q;
  logic                 ofull, opush, opop;

  assign ofull  = (ocnt_q == 2'd2);
  assign en     = !ofull;
  assign take_o = en && valid_i;

  // Rotation about z, then y, then x.
  cpp_rot u_rot_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i),
    .u_i(head_i.x), .v_i(head_i.y), .w_i(head_i.z),
    .c_i(terms_i.cos_z), .s_i(terms_i.sin_z),
    .valid_o(r0_valid), .u_o(r0_u), .v_o(r0_v), .w_o(r0_w)
  );

  cpp_rot u_rot_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r0_valid),
    .u_i(r0_u), .v_i(r0_w), .w_i(r0_v),
    .c_i(terms_i.cos_y), .s_i(terms_i.sin_y),
    .valid_o(r1_valid), .u_o(r1_u), .v_o(r1_v), .w_o(r1_w)
  );

  cpp_rot u_rot_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r1_valid),
    .u_i(r1_w), .v_i(r1_v), .w_i(r1_u),
    .c_i(terms_i.cos_x), .s_i(terms_i.sin_x),
    .valid_o(r2_valid), .u_o(r2_u), .v_o(r2_v), .w_o(r2_w)
  );

  // Near-plane clip and magnitudes; x is r2_w, y is r2_u, depth is r2_v.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_clip_q  <= (r2_v <= NEAR_LIMIT);
      p_neg_x_q <= r2_w[CW-1];
      p_neg_y_q <= r2_u[CW-1];
      p_mag_x_q <= r2_w[CW-1] ? (CW'(0) - r2_w) : r2_w;
      p_mag_y_q <= r2_u[CW-1] ? (CW'(0) - r2_u) : r2_u;
      p_den_q   <= r2_v;
      m_clip_q  <= p_clip_q;
      m_neg_x_q <= p_neg_x_q;
      m_neg_y_q <= p_neg_y_q;
      m_num_x_q <= NW'(p_mag_x_q) * NW'(focal_i);
      m_num_y_q <= NW'(p_mag_y_q) * NW'(focal_i);
      m_den_q   <= p_den_q;
    end
  end

  // Divider setup: overflow check against the magnitude cap and the first remainder.
  always_comb begin
    lim          = OW'(m_den_q) << (QW - FRAC_BITS);
    sh_x         = m_num_x_q >> (QW - FRAC_BITS);
    sh_y         = m_num_y_q >> (QW - FRAC_BITS);
    shl_x        = m_num_x_q << FRAC_BITS;
    shl_y        = m_num_y_q << FRAC_BITS;
    d0.lx.rem    = sh_x[RW-1:0];
    d0.lx.low    = shl_x[QW-1:0];
    d0.lx.q      = '0;
    d0.ly.rem    = sh_y[RW-1:0];
    d0.ly.low    = shl_y[QW-1:0];
    d0.ly.q      = '0;
    d0.den       = m_den_q;
    d0.neg_x     = m_neg_x_q;
    d0.neg_y     = m_neg_y_q;
    d0.ovf_x     = (OW'(m_num_x_q) >= lim);
    d0.ovf_y     = (OW'(m_num_y_q) >= lim);
    d0.clip      = m_clip_q;
  end

  // Divider pipeline, one quotient bit per stage for each axis.
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= d0;
      for (int i = 0; i < QW; i++) begin
        st_q[i+1] <= div_next(st_q[i]);
      end
    end
  end

  // Valid bits of the clip, multiply and divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i <= QW; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (en) begin
      p_valid_q <= r2_valid;
      m_valid_q <= p_valid_q;
      dv_q[0]   <= m_valid_q;
      for (int i = 0; i < QW; i++) begin
        dv_q[i+1] <= dv_q[i];
      end
    end
  end

  // Final sign, centering and saturation.
  always_comb begin
    if (st_q[QW].clip) begin
      res.screen_x = CLIP_VALUE;
      res.screen_y = CLIP_VALUE;
      res.clipped  = 1'b1;
    end else begin
      res.screen_x = finish(st_q[QW].lx.q, st_q[QW].ovf_x, st_q[QW].neg_x, HALF_X);
      res.screen_y = finish(st_q[QW].ly.q, st_q[QW].ovf_y, st_q[QW].neg_y, HALF_Y);
      res.clipped  = 1'b0;
    end
  end

  // Two-entry result queue; the pipeline stalls only while it is full.
  assign opush      = en && dv_q[QW];
  assign empty_o    = (ocnt_q == 2'd0);
  assign opop       = pop_i && !empty_o;
  assign out_data_o = ofq[orp_q];

  always_ff @(posedge clk_i) begin
    if (opush) begin
      ofq[owp_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) owp_q <= !owp_q;
      if (opop)  orp_q <= !orp_q;
      unique case ({opush, opop})
        2'b10:   ocnt_q <= ocnt_q + 2'd1;
        2'b01:   ocnt_q <= ocnt_q - 2'd1;
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/camera_perspective_projection_unit.sv =====
// The rotation, multiply and 33-stage divider stages are pipelined behind the input queue.
// Throughput: one point per cycle while neither full nor a full result queue stalls the flow.
// An angle write holds full high while the shared trig multiplier recomputes its axis.
// Reset (rst_ni low, asynchronous) empties both queues and loads the camera defaults:
// position (0, 0, -5.0), angles zero, focal scale 640, cosine terms 1.0 and sine terms 0.
`default_nettype none
`include "assert_macros.svh"
module camera_perspective_projection_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  cpp_pkg::in_item_t        in_data_i,
  output logic                     empty,
  input  logic                     pop,
  output cpp_pkg::out_item_t       out_data_o,
  input  logic                     cfg_we_i,
  input  logic [cpp_pkg::IW-1:0]   cfg_idx_i,
  input  logic [cpp_pkg::DW-1:0]   cfg_data_i
);
  import cpp_pkg::*;

  cam_pos_t      cam_pos_q;
  logic [FW-1:0] focal_q;
  angle_wr_t     angle_wr;
  rot_terms_t    terms;
  logic          trig_busy;
  logic          q_empty, q_take;
  vec_t          q_head;

  // Camera position and focal scale registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_pos_q.x <= '0;
      cam_pos_q.y <= '0;
      cam_pos_q.z <= CAM_POS_Z_RESET;
      focal_q     <= FOCAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CAM_POS_X:   cam_pos_q.x <= cfg_data_i;
        REG_CAM_POS_Y:   cam_pos_q.y <= cfg_data_i;
        REG_CAM_POS_Z:   cam_pos_q.z <= cfg_data_i;
        REG_FOCAL_SCALE: focal_q     <= cfg_data_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // Angle writes go to the trig sequencer.
  always_comb begin
    angle_wr.we    = 1'b0;
    angle_wr.axis  = AXIS_X;
    angle_wr.value = cfg_data_i[AW-1:0];
    unique case (cfg_reg_e'(cfg_idx_i))
      REG_CAM_ANGLE_X: begin
        angle_wr.we   = cfg_we_i;
        angle_wr.axis = AXIS_X;
      end
      REG_CAM_ANGLE_Y: begin
        angle_wr.we   = cfg_we_i;
        angle_wr.axis = AXIS_Y;
      end
      REG_CAM_ANGLE_Z: begin
        angle_wr.we   = cfg_we_i;
        angle_wr.axis = AXIS_Z;
      end
      default: ;
    endcase
  end

  cpp_trig u_trig (
    .clk_i, .rst_ni,
    .angle_wr_i(angle_wr),
    .terms_o(terms),
    .busy_o(trig_busy)
  );

  cpp_front u_front (
    .clk_i, .rst_ni,
    .push_i(push),
    .in_data_i,
    .cam_pos_i(cam_pos_q),
    .hold_i(trig_busy),
    .full_o(full),
    .take_i(q_take),
    .empty_o(q_empty),
    .head_o(q_head)
  );

  cpp_back u_back (
    .clk_i, .rst_ni,
    .valid_i(!q_empty),
    .head_i(q_head),
    .take_o(q_take),
    .terms_i(terms),
    .focal_i(focal_q),
    .pop_i(pop),
    .empty_o(empty),
    .out_data_o
  );

  // New points are never accepted while the rotation terms are being rebuilt.
  `ASSERT_CHK(a_busy_blocks_input, trig_busy |-> full)
  // A clipped result always carries the sentinel coordinates.
  `ASSERT_CHK(a_clip_sentinel, (!empty && out_data_o.clipped) |->
      (out_data_o.screen_x == CLIP_VALUE && out_data_o.screen_y == CLIP_VALUE))
  // An angle write closes the input on the next cycle.
  `ASSERT_CHK(a_angle_write_stalls, angle_wr.we |=> full)

endmodule
`default_nettype wire
